// ----- src/tdq_pkg.sv -----
// Shared types and constants for the timed transport delay queue.
// No dependencies; imported by tdq_csr and the top level.
`default_nettype none

package tdq_pkg;

   // Queue depth and derived widths
   localparam int DEPTH      = 128;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // Field widths
   localparam int FUNC_W     = 2;
   localparam int VALUE_W    = 32;
   localparam int DELAY_W    = 16;
   localparam int TICKS_W    = 20;
   localparam int TIME_W     = 48;
   localparam int PENDING_W  = 8;
   localparam int PROD_W     = DELAY_W + TICKS_W;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_MS   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_OUTPUT = CSR_IDX_W'(1);

   // Reset values
   localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(1000);
   localparam logic [VALUE_W-1:0] HELD_RESET  = '0;

   // Answer on push: -1.0 in single precision
   localparam logic [VALUE_W-1:0] PUSH_ANSWER = 32'hBF80_0000;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH = 2'd0,
      FUNC_EVAL = 2'd1,
      FUNC_TICK = 2'd2,
      FUNC_NOP  = 2'd3
   } func_type;

   typedef enum logic {
      ST_IDLE,
      ST_BUSY
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0]  due;
      logic [VALUE_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic [TICKS_W-1:0] ticks_per_ms;
      logic               load_init;
      logic [VALUE_W-1:0] init_value;
   } csr_ctl_type;

endpackage

`default_nettype wire

// ----- src/tdq_ram.sv -----
// Generic single-write, single-read synchronous RAM, registered read data.
// Standalone; no package dependency.
`default_nettype none

module tdq_ram #(
   parameter int WIDTH  = 80,
   parameter int DEPTH_P = 128
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH_P)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH_P)-1:0] rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH_P];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- src/tdq_csr.sv -----
// Configuration registers: ticks per millisecond and initial output load.
// Depends on tdq_pkg.
`default_nettype none

module tdq_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [tdq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tdq_pkg::CSR_DATA_W-1:0]  csr_data,
   output tdq_pkg::csr_ctl_type                 csr_ctl
);
   import tdq_pkg::*;

   logic [TICKS_W-1:0] ticks_ff;
   logic [TICKS_W-1:0] ticks_in;
   logic               wr_fire;

   assign csr_ready = 1'b1;  // never stalls a write
   assign wr_fire   = csr_valid && csr_ready;

   always_comb begin
      ticks_in = ticks_ff;
      if (wr_fire && (csr_index == CSR_TICKS_PER_MS)) begin
         ticks_in = csr_data[TICKS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= TICKS_RESET;
      end else begin
         ticks_ff <= ticks_in;
      end
   end

   always_comb begin
      csr_ctl.ticks_per_ms = ticks_ff;
      csr_ctl.load_init    = wr_fire && (csr_index == CSR_INITIAL_OUTPUT);
      csr_ctl.init_value   = csr_data[VALUE_W-1:0];
   end

endmodule

`default_nettype wire

// ----- src/timed_transport_delay_queue.sv -----
// Timed transport delay queue, top level: control FSM, queue pointers, time counter.
// Depends on tdq_pkg, tdq_ram and tdq_csr.
//
// Usage:
//  - req_ channel: one beat per operation. req_func selects push (store
//    req_sample_value, due at now + req_delay_ms * ticks_per_ms), evaluate
//    (release the head sample into the held output once now > due, then
//    return the held output) or tick (advance the 48-bit time counter).
//  - rsp_ channel: exactly one beat per request, in order. rsp_out_value is
//    the held output, or 0xBF800000 on push; rsp_dropped flags a push into
//    a full queue; rsp_pending is the queue occupancy after the operation.
//  - csr_ channel: index 0 ticks_per_ms, index 1 initial_output (also loads
//    the held output). Other indexes are ignored. Write only while idle.
// Timing:
//  - Sequence: a request is accepted and captured in the idle state; the busy
//    state commits it and registers its response, raising rsp_valid.
//  - Acceptance: no new request is taken until the busy beat commits. The queue
//    RAM's registered read (evaluate) and registered delay multiply (push) set this.
//  - Receiver stall: the request waits in the busy state until the response
//    register frees; no state changes until then.
// Reset: queue empty, time zero, held output zero, ticks_per_ms 1000.
//  No clearing pass; only occupied entries are ever used.
`default_nettype none

module timed_transport_delay_queue (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [tdq_pkg::FUNC_W-1:0]      req_func,
   input  wire logic [tdq_pkg::VALUE_W-1:0]     req_sample_value,
   input  wire logic [tdq_pkg::DELAY_W-1:0]     req_delay_ms,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [tdq_pkg::VALUE_W-1:0]     rsp_out_value,
   output logic                                 rsp_dropped,
   output logic      [tdq_pkg::PENDING_W-1:0]   rsp_pending,
   // configuration channel
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [tdq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tdq_pkg::CSR_DATA_W-1:0]  csr_data
);
   import tdq_pkg::*;

   localparam int ENTRY_W = $bits(entry_type);

   // FSM
   state_type state_ff, state_in;
   logic      commit;      // busy beat retires this cycle
   logic      out_free;    // response register can take a beat
   logic      req_fire;

   // Captured request beat
   func_type            func_ff;
   logic [VALUE_W-1:0]  sample_ff;
   logic [PROD_W-1:0]   product_ff;

   // Queue and time state
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [VALUE_W-1:0]  held_ff, held_in;
   logic                full;

   // Response register
   logic                rsp_valid_ff;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                rsp_dropped_ff, rsp_dropped_in;
   logic [PENDING_W-1:0] rsp_pending_ff;

   // RAM
   logic                ram_wr_en;
   entry_type           wr_entry;
   logic                ram_rd_en;
   logic [ENTRY_W-1:0]  ram_rd_data;
   entry_type           rd_entry;

   csr_ctl_type         csr_ctl;

   tdq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_ctl   (csr_ctl)
   );

   tdq_ram #(
      .WIDTH   (ENTRY_W),
      .DEPTH_P (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = ram_rd_data;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] res;
      if (idx == IDX_W'(DEPTH - 1)) begin
         res = '0;
      end else begin
         res = idx + IDX_W'(1);
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- FSM
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_fire = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_BUSY: commit    = out_free;
         default: ;
      endcase
      // head entry is fetched as the evaluate beat comes in
      ram_rd_en = req_fire && (func_type'(req_func) == FUNC_EVAL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture stage: delay scaling multiply is registered here
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff    <= func_type'(req_func);
         sample_ff  <= req_sample_value;
         product_ff <= PROD_W'(req_delay_ms) * PROD_W'(csr_ctl.ticks_per_ms);
      end
   end

   // ------------------------------------------------------- commit logic
   assign full = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      time_in        = time_ff;
      held_in        = held_ff;
      ram_wr_en      = 1'b0;
      wr_entry.value = sample_ff;
      wr_entry.due   = time_ff + TIME_W'(product_ff);
      rsp_value_in   = held_ff;
      rsp_dropped_in = 1'b0;
      priority if (commit) begin
         unique case (func_ff)
            FUNC_PUSH: begin
               rsp_value_in = PUSH_ANSWER;
               if (full) begin
                  rsp_dropped_in = 1'b1;
               end else begin
                  ram_wr_en = 1'b1;
                  tail_in   = next_slot(tail_ff);
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            FUNC_EVAL: begin
               // strictly later than due releases the head
               if ((count_ff != '0) && (time_ff > rd_entry.due)) begin
                  held_in  = rd_entry.value;
                  head_in  = next_slot(head_ff);
                  count_in = count_ff - CNT_W'(1);
               end
               rsp_value_in = held_in;
            end
            FUNC_TICK: begin
               time_in = time_ff + TIME_W'(1);
            end
            FUNC_NOP: ;
            default: ;
         endcase
      end else if (csr_ctl.load_init) begin
         held_in = csr_ctl.init_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         time_ff  <= '0;
         held_ff  <= HELD_RESET;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         time_ff  <= time_in;
         held_ff  <= held_in;
      end
   end

   // ---------------------------------------------------- response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_value_ff   <= rsp_value_in;
         rsp_dropped_ff <= rsp_dropped_in;
         rsp_pending_ff <= PENDING_W'(count_in);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_dropped   = rsp_dropped_ff;
   assign rsp_pending   = rsp_pending_ff;

   // ------------------------------------------------------------ checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy above depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with head and tail apart");

   a_full_ptrs: assert property (@(posedge clock) disable iff (reset)
      full |-> (head_ff == tail_ff))
      else $error("full queue with head and tail apart");

   a_tick_adv: assert property (@(posedge clock) disable iff (reset)
      (commit && (func_ff == FUNC_TICK)) |=> (time_ff == $past(time_ff) + TIME_W'(1)))
      else $error("tick did not advance time");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_dropped_ff) |-> (rsp_pending_ff == PENDING_W'(DEPTH)))
      else $error("drop reported with queue not full");

endmodule

`default_nettype wire

// ----- sim/tb_timed_transport_delay_queue.sv -----
// Self-checking testbench for timed_transport_delay_queue: directed and random
// push/evaluate/tick beats against a scoreboard that models the queue and time counter.
// Depends on tdq_pkg and the timed_transport_delay_queue RTL.

module tb_timed_transport_delay_queue;
   import tdq_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;   // idle cycles
   localparam int RANDOM_ITEMS   = 1250;
   localparam int MAX_GAP        = 18;
   localparam int PRINT_CAP      = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = CSR_INITIAL_OUTPUT + 1'b1;

   typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } mix_type;

   typedef struct packed {
      logic [VALUE_W-1:0]   value;
      logic                 dropped;
      logic [PENDING_W-1:0] pending;
   } answer_type;

   // Tracks queue, time counter and held output; holds the answers still owed.
   class delay_queue_scoreboard;
      logic [VALUE_W-1:0] sample_mem [DEPTH];
      logic [TIME_W-1:0]  due_mem [DEPTH];
      int unsigned        head, tail, occupancy;
      logic [TIME_W-1:0]  now;
      logic [VALUE_W-1:0] held;
      logic [TICKS_W-1:0] ticks_per_ms;
      answer_type         answers [$];
      int errors, checked, pushes, drops, releases, tick_count, writes, peak;

      function new();
         head         = 0;
         tail         = 0;
         occupancy    = 0;
         now          = '0;
         held         = HELD_RESET;
         ticks_per_ms = TICKS_RESET;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         writes++;
         if (index == CSR_TICKS_PER_MS) begin
            ticks_per_ms = data[TICKS_W-1:0];
         end else if (index == CSR_INITIAL_OUTPUT) begin
            held = data[VALUE_W-1:0];   // also reloads the held output
         end
      endfunction

      function void note_request(func_type op, logic [VALUE_W-1:0] sample,
                                 logic [DELAY_W-1:0] delay);
         answer_type want;
         want.dropped = 1'b0;
         case (op)
            FUNC_PUSH: begin
               if (occupancy >= DEPTH) begin
                  want.dropped = 1'b1;
                  drops++;
               end else begin
                  sample_mem[tail] = sample;
                  due_mem[tail]    = now + TIME_W'(delay) * TIME_W'(ticks_per_ms);
                  tail             = (tail + 1) % DEPTH;
                  occupancy++;
                  pushes++;
               end
            end
            FUNC_EVAL: begin
               // only the head may leave, and only once strictly past due
               if (occupancy != 0 && now > due_mem[head]) begin
                  held = sample_mem[head];
                  head = (head + 1) % DEPTH;
                  occupancy--;
                  releases++;
               end
            end
            FUNC_TICK: begin
               now = now + 1'b1;
               tick_count++;
            end
            default: ;
         endcase
         want.value   = (op == FUNC_PUSH) ? PUSH_ANSWER : held;
         want.pending = PENDING_W'(occupancy);
         if (occupancy > peak) peak = occupancy;
         answers.push_back(want);
      endfunction

      function void report_mismatch(string msg);
         if (errors < PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
         errors++;
      endfunction

      function void check_answer(logic [VALUE_W-1:0] value, logic dropped,
                                 logic [PENDING_W-1:0] pending);
         answer_type want;
         if (answers.size() == 0) begin
            report_mismatch($sformatf("response beat with nothing outstanding, value %h", value));
            return;
         end
         want = answers.pop_front();
         checked++;
         if (value !== want.value)
            report_mismatch($sformatf("beat %0d out_value %h, want %h",
                                      checked, value, want.value));
         if (dropped !== want.dropped)
            report_mismatch($sformatf("beat %0d dropped %b, want %b",
                                      checked, dropped, want.dropped));
         if (pending !== want.pending)
            report_mismatch($sformatf("beat %0d pending %0d, want %0d",
                                      checked, pending, want.pending));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [FUNC_W-1:0]      req_func = '0;
   logic [VALUE_W-1:0]     req_sample_value = '0;
   logic [DELAY_W-1:0]     req_delay_ms = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [VALUE_W-1:0]     rsp_out_value;
   logic                   rsp_dropped;
   logic [PENDING_W-1:0]   rsp_pending;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   delay_queue_scoreboard  sb = new();
   bit                     no_gaps = 1'b0;   // back-to-back request beats when set

   timed_transport_delay_queue DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_sample_value (req_sample_value),
      .req_delay_ms     (req_delay_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_value    (rsp_out_value),
      .rsp_dropped      (rsp_dropped),
      .rsp_pending      (rsp_pending),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #4 clock = ~clock;

   // Response side: check each beat, then hold off for a random stall, with stretches of
   // zero stall. All handshake signals are sampled as they stood before the edge.
   int rsp_hold, quiet_left, stall;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold   = 0;
         quiet_left = 0;
      end else if (rsp_valid && rsp_ready) begin
         sb.check_answer(rsp_out_value, rsp_dropped, rsp_pending);
         if (quiet_left > 0) begin
            quiet_left--;
            stall = 0;
         end else begin
            if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(20, 60);
            stall = $urandom_range(0, MAX_GAP);
         end
         rsp_ready <= (stall == 0);
         rsp_hold   = stall - 1;
      end else if (!rsp_ready) begin
         if (rsp_hold <= 0) rsp_ready <= 1'b1;
         else rsp_hold--;
      end
   end

   // Watchdog: any beat on any channel restarts the count.
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("%0t watchdog: no beat for %0d cycles, %0d answers owed",
               $time, WATCHDOG_LIMIT, sb.answers.size());
      $display("tb_timed_transport_delay_queue: done, errors");
      $finish;
   end

   // One request beat, preceded by a random idle gap unless no_gaps is set.
   task automatic send_item(input func_type op, input logic [VALUE_W-1:0] sample,
                            input logic [DELAY_W-1:0] delay);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= op;
      req_sample_value <= sample;
      req_delay_ms     <= delay;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, sample, delay);
   endtask

   // Hold off the sender until every owed answer is back, plus the pipeline latency.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.answers.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, data);
   endtask

   // Back-to-back register beats; valid drops only after the last one.
   task automatic configure(input logic [CSR_DATA_W-1:0] ticks_data, input bit load_init,
                            input logic [CSR_DATA_W-1:0] init_data, input bit poke_unused);
      put_reg(CSR_TICKS_PER_MS, ticks_data);
      if (load_init) put_reg(CSR_INITIAL_OUTPUT, init_data);
      if (poke_unused)
         put_reg(CSR_IDX_W'($urandom_range(CSR_FIRST_UNUSED, 2**CSR_IDX_W - 1)), $urandom);
      csr_valid <= 1'b0;
   endtask

   function automatic func_type pick_func(mix_type mix);
      int r, push_lim, eval_lim;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  begin push_lim = 80; eval_lim = 88; end
         MIX_DRAIN: begin push_lim = 10; eval_lim = 55; end
         default:   begin push_lim = 35; eval_lim = 65; end
      endcase
      if (r < push_lim) return FUNC_PUSH;
      if (r < eval_lim) return FUNC_EVAL;
      if (r < 95) return FUNC_TICK;
      return FUNC_NOP;
   endfunction

   // Keep due times close enough that the head always drains: any delay at zero
   // scale, short delays at small scales, none at large scales.
   function automatic logic [DELAY_W-1:0] pick_delay(logic [TICKS_W-1:0] scale);
      if (scale == '0) return DELAY_W'($urandom);
      if (scale <= 4) return DELAY_W'($urandom_range(0, 6));
      return '0;
   endfunction

   initial begin : stimulus
      func_type           op;
      logic [TICKS_W-1:0] scale;
      mix_type            mix;
      int                 items, phase, length;

      items = 0;
      phase = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset scale of 1000, so only zero-delay pushes here
      send_item(FUNC_EVAL, '0, '0);              // empty queue
      send_item(FUNC_NOP, '1, '1);               // unused selector
      send_item(FUNC_PUSH, '1, '0);              // due == now
      send_item(FUNC_EVAL, '0, '0);              // now == due: not yet
      send_item(FUNC_TICK, '1, '1);
      send_item(FUNC_EVAL, '0, '0);              // strictly past due: released
      send_item(FUNC_EVAL, '1, '1);              // empty again
      settle();
      // zero scale (upper data bits must be ignored), reload held output, stray index
      configure(32'hFFF0_0000, 1'b1, 32'h5A5A_A5A5, 1'b1);
      send_item(FUNC_EVAL, '0, '0);
      send_item(FUNC_PUSH, '0, '1);              // max delay, zero scale
      send_item(FUNC_EVAL, '0, '0);
      send_item(FUNC_TICK, '0, '0);
      send_item(FUNC_EVAL, '0, '0);
      send_item(FUNC_PUSH, 32'hA5A5_5A5A, 16'h5555);
      send_item(FUNC_PUSH, 32'h7FFF_FFFF, 16'hAAAA);
      settle();
      configure('1, 1'b1, '0, 1'b0);             // max scale, held output to zero
      send_item(FUNC_PUSH, 32'h8000_0001, '0);
      send_item(FUNC_EVAL, '0, '0);
      send_item(FUNC_TICK, '0, '0);
      send_item(FUNC_EVAL, '0, '0);
      send_item(FUNC_EVAL, '0, '0);
      send_item(FUNC_EVAL, '0, '0);

      // Random phases: scale cycles through its extremes; every fourth phase
      // fills the queue past full
      while (items < RANDOM_ITEMS) begin
         settle();
         case (phase % 5)
            0:       scale = '0;
            1:       scale = TICKS_W'(1);
            2:       scale = TICKS_W'($urandom_range(2, 4));
            3:       scale = '1;
            default: scale = TICKS_W'($urandom_range(5, 2**TICKS_W - 1));
         endcase
         configure({12'($urandom), scale}, $urandom_range(0, 1), $urandom,
                   $urandom_range(0, 3) == 0);
         mix     = (phase % 4 == 0) ? MIX_FILL : mix_type'($urandom_range(1, 2));
         length  = (mix == MIX_FILL) ? 200 : $urandom_range(40, 120);
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < length; n++) begin
            op = pick_func(mix);
            items++;
            send_item(op, $urandom, pick_delay(scale));
            if ($urandom_range(0, 199) == 0) settle();
         end
         phase++;
      end

      // Last: large scale times large delay; these stay queued, so any early
      // release points to a truncated due time
      settle();
      configure({12'($urandom), TICKS_W'($urandom_range(2**(TICKS_W-1), 2**TICKS_W - 1))},
                1'b0, '0, 1'b0);
      no_gaps = 1'b0;
      repeat (20) begin
         op = pick_func(MIX_EVEN);
         send_item(op, $urandom, DELAY_W'($urandom_range(1, 2**DELAY_W - 1)));
      end
      settle();

      $display("covered %0d answers over %0d phases, %0d register writes, peak occupancy %0d",
               sb.checked, phase + 1, sb.writes, sb.peak);
      $display("queued %0d, dropped on full %0d, released %0d, ticks %0d",
               sb.pushes, sb.drops, sb.releases, sb.tick_count);
      if (sb.errors == 0) begin
         $display("tb_timed_transport_delay_queue: done, clean");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("tb_timed_transport_delay_queue: done, errors");
      end
      $finish;
   end

endmodule
